[rtl/rspcv_pkg.sv]
// Package for the random stepped pitch CV generator.
// Holds the command and micro-op codes, the controller/datapath status struct and the pitch tables.
// No dependencies.
package rspcv_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_NOTE,
        OP_PHASE,
        OP_LCG,
        OP_UNQ,
        OP_ET_PICK,
        OP_ET_NOTE,
        OP_FREQ,
        OP_J_BASE,
        OP_J_OCT,
        OP_J_MUL,
        OP_J_DIV,
        OP_J_SHIFT,
        OP_CV2,
        OP_CV1,
        OP_SLEW_DIFF,
        OP_SLEW_MUL,
        OP_SLEW_APPLY,
        OP_DAC_MUL,
        OP_DAC_SCALE,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic tick_active;
        logic wrap;
        logic root_zero;
        logic just;
    } dp_status_t;

    localparam int REG_PHASE_INC = 0;
    localparam int REG_SLEW      = 1;
    localparam int REG_ROOT      = 2;
    localparam int REG_RANGE     = 3;
    localparam int REG_JUST      = 4;

    localparam logic [22:0] PITCH_MAX   = 23'd8388607;
    localparam logic [23:0] PITCH_RESET = 24'd56320;

    // Q16 frequencies of the top octave, notes 120..131
    function automatic logic [31:0] top_octave(input logic [3:0] s);
        case (s)
            4'd0:    top_octave = 32'd548668578;
            4'd1:    top_octave = 32'd581294109;
            4'd2:    top_octave = 32'd615859655;
            4'd3:    top_octave = 32'd652480576;
            4'd4:    top_octave = 32'd691279090;
            4'd5:    top_octave = 32'd732384684;
            4'd6:    top_octave = 32'd775934544;
            4'd7:    top_octave = 32'd822074013;
            4'd8:    top_octave = 32'd870957077;
            4'd9:    top_octave = 32'd922746880;
            4'd10:   top_octave = 32'd977616265;
            default: top_octave = 32'd1035748353;
        endcase
    endfunction

    // quotient by 12 for values below 128: multiply by 171/2048
    function automatic logic [3:0] div12(input logic [6:0] n);
        logic [14:0] t;
        t = 15'(n) * 15'd171;
        div12 = t[14:11];
    endfunction

    // note number to Q8 Hz, rounded
    function automatic logic [22:0] note_freq(input logic [6:0] n);
        logic [3:0]  k;
        logic [3:0]  s;
        logic [4:0]  sh;
        logic [31:0] v;
        k  = div12(n);
        s  = 4'(n - 7'(k) * 7'd12);
        sh = 5'd18 - 5'(k);
        v  = top_octave(s) + (32'd1 << (sh - 5'd1));
        note_freq = 23'(v >> sh);
    endfunction

    // snap a semitone offset down to the major scale
    function automatic logic [3:0] major_snap(input logic [3:0] left);
        case (left)
            4'd0, 4'd1:  major_snap = 4'd0;
            4'd2, 4'd3:  major_snap = 4'd2;
            4'd4:        major_snap = 4'd4;
            4'd5, 4'd6:  major_snap = 4'd5;
            4'd7, 4'd8:  major_snap = 4'd7;
            4'd9, 4'd10: major_snap = 4'd9;
            default:     major_snap = 4'd11;
        endcase
    endfunction

    function automatic logic [3:0] just_num(input logic [2:0] i);
        case (i)
            3'd0:    just_num = 4'd1;
            3'd1:    just_num = 4'd9;
            3'd2:    just_num = 4'd5;
            3'd3:    just_num = 4'd4;
            3'd4:    just_num = 4'd3;
            3'd5:    just_num = 4'd5;
            3'd6:    just_num = 4'd15;
            default: just_num = 4'd2;
        endcase
    endfunction

    // denominator: 3 flags a divide by three, else the shift for a power of two
    function automatic logic just_den3(input logic [2:0] i);
        just_den3 = (i == 3'd3) || (i == 3'd5);
    endfunction

    function automatic logic [1:0] just_den_shift(input logic [2:0] i);
        case (i)
            3'd1, 3'd6: just_den_shift = 2'd3;
            3'd2:       just_den_shift = 2'd2;
            3'd4:       just_den_shift = 2'd1;
            default:    just_den_shift = 2'd0;
        endcase
    endfunction

endpackage

[rtl/rspcv_ctrl.sv]
// Controller state machine of the random stepped pitch CV generator.
// Sequences micro-ops for the datapath and owns the stream handshakes.
// Depends on rspcv_pkg.
module rspcv_ctrl import rspcv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output op_t        op
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_CHECK, S_LCG_P, S_UNQ, S_ET_PICK, S_ET_NOTE, S_FREQ,
        S_J_BASE, S_LCG_J, S_J_OCT, S_J_MUL, S_J_DIV, S_J_SHIFT,
        S_LCG_C2, S_CV2, S_LCG_C1, S_CV1,
        S_SLEW_DIFF, S_SLEW_MUL, S_SLEW_APPLY, S_DAC_MUL, S_DAC_SCALE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        op            = OP_NONE;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.tick_active) begin
                    op         = OP_PHASE;
                    state_next = S_CHECK;
                end else begin
                    op         = OP_NOTE;
                    state_next = S_DAC_MUL;
                end
            end
            S_CHECK:      state_next = status.wrap ? S_LCG_P : S_SLEW_DIFF;
            S_LCG_P: begin
                op = OP_LCG;
                if (status.root_zero) state_next = S_UNQ;
                else if (status.just) state_next = S_J_BASE;
                else state_next = S_ET_PICK;
            end
            S_UNQ:        begin op = OP_UNQ;        state_next = S_LCG_C2;     end
            S_ET_PICK:    begin op = OP_ET_PICK;    state_next = S_ET_NOTE;    end
            S_ET_NOTE:    begin op = OP_ET_NOTE;    state_next = S_FREQ;       end
            S_FREQ:       begin op = OP_FREQ;       state_next = S_LCG_C2;     end
            S_J_BASE:     begin op = OP_J_BASE;     state_next = S_LCG_J;      end
            S_LCG_J:      begin op = OP_LCG;        state_next = S_J_OCT;      end
            S_J_OCT:      begin op = OP_J_OCT;      state_next = S_J_MUL;      end
            S_J_MUL:      begin op = OP_J_MUL;      state_next = S_J_DIV;      end
            S_J_DIV:      begin op = OP_J_DIV;      state_next = S_J_SHIFT;    end
            S_J_SHIFT:    begin op = OP_J_SHIFT;    state_next = S_LCG_C2;     end
            S_LCG_C2:     begin op = OP_LCG;        state_next = S_CV2;        end
            S_CV2:        begin op = OP_CV2;        state_next = S_LCG_C1;     end
            S_LCG_C1:     begin op = OP_LCG;        state_next = S_CV1;        end
            S_CV1:        begin op = OP_CV1;        state_next = S_SLEW_DIFF;  end
            S_SLEW_DIFF:  begin op = OP_SLEW_DIFF;  state_next = S_SLEW_MUL;   end
            S_SLEW_MUL:   begin op = OP_SLEW_MUL;   state_next = S_SLEW_APPLY; end
            S_SLEW_APPLY: begin op = OP_SLEW_APPLY; state_next = S_DAC_MUL;    end
            S_DAC_MUL:    begin op = OP_DAC_MUL;    state_next = S_DAC_SCALE;  end
            S_DAC_SCALE:  begin op = OP_DAC_SCALE;  state_next = S_OUT;        end
            S_OUT: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    op            = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/rspcv_dp.sv]
// Datapath of the random stepped pitch CV generator.
// Holds configuration, note state, LCG, pitch draw, slew and DAC scaling; runs one micro-op a cycle.
// Depends on rspcv_pkg.
module rspcv_dp import rspcv_pkg::*; #(
    parameter int RANDOM_FRACTION_BITS = 24,
    parameter int DAC_BITS             = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  in_cmd,
    input  logic [47:0] in_data,
    input  op_t         op,
    output dp_status_t  status,
    output logic [47:0] out_data,
    output logic        out_new_step
);

    localparam int RFB = RANDOM_FRACTION_BITS;
    localparam logic [15:0] DAC_FULL = 16'((32'd1 << DAC_BITS) - 32'd1);

    // configuration
    logic [31:0] phase_inc_reg;
    logic [16:0] slew_coef_reg;
    logic [3:0]  root_reg;
    logic [3:0]  range_reg;
    logic        just_reg;

    // note and step state
    logic [31:0] seed_reg;
    logic [31:0] phase_reg;
    logic        active_reg;
    logic [6:0]  held_reg;
    logic        wrap_reg;
    logic [23:0] now_reg [3];
    logic [23:0] tgt_reg [3];

    // latched item
    logic [1:0]  cmd_reg;
    logic [6:0]  note_reg;
    logic [6:0]  vel_reg;
    logic [15:0] gain_reg [2];

    // working registers
    logic [6:0]  pick_reg;
    logic [6:0]  et_note_reg;
    logic [2:0]  jidx_reg;
    logic [16:0] base_reg;
    logic [2:0]  oct_reg;
    logic [20:0] jprod_reg;
    logic [19:0] jquo_reg;
    logic [23:0] diff_reg [3];
    logic [23:0] step_reg [3];
    logic [39:0] dprod_reg [2];
    logic [11:0] code_reg [2];
    logic [47:0] out_data_reg;
    logic        out_new_reg;

    logic [RFB-1:0] rnd;
    logic [3:0]     root_c;
    logic [3:0]     semi;
    logic [32:0]    phase_sum;
    logic [3:0]     pick_q;
    logic [3:0]     pick_left;
    logic [7:0]     et_sum;
    logic [2:0]     maxo;
    logic [26:0]    jshift;

    assign rnd       = seed_reg[31 -: RFB];
    assign root_c    = (root_reg > 4'd12) ? 4'd12 : root_reg;
    assign semi      = root_c - 4'd1;
    assign phase_sum = {1'b0, phase_reg} + {1'b0, phase_inc_reg};
    assign pick_q    = div12(pick_reg);
    assign pick_left = 4'(pick_reg - 7'(pick_q) * 7'd12);
    assign et_sum    = 8'd48 + 8'(pick_q) * 8'd12 + 8'(major_snap(pick_left)) + 8'(semi);
    assign maxo      = range_reg[3:1];
    assign jshift    = 27'(jquo_reg) << oct_reg;

    assign status.tick_active = (cmd_t'(cmd_reg) == CMD_TICK) && active_reg;
    assign status.wrap        = wrap_reg;
    assign status.root_zero   = (root_reg == 4'd0);
    assign status.just        = just_reg;

    assign out_data     = out_data_reg;
    assign out_new_step = out_new_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= 32'd29826;
            slew_coef_reg <= 17'd65536;
            root_reg      <= 4'd0;
            range_reg     <= 4'd2;
            just_reg      <= 1'b0;
            seed_reg      <= '0;
            phase_reg     <= '0;
            active_reg    <= 1'b0;
            held_reg      <= '0;
            wrap_reg      <= 1'b0;
            cmd_reg       <= CMD_NOP;
            for (int i = 0; i < 3; i++) begin
                now_reg[i] <= (i == 0) ? PITCH_RESET : 24'd0;
                tgt_reg[i] <= (i == 0) ? PITCH_RESET : 24'd0;
            end
        end else begin
            if (cfg_we) begin
                case (int'(cfg_index))
                    REG_PHASE_INC: phase_inc_reg <= cfg_data;
                    REG_SLEW:      slew_coef_reg <= cfg_data[16:0];
                    REG_ROOT:      root_reg      <= cfg_data[3:0];
                    REG_RANGE:     range_reg     <= cfg_data[3:0];
                    REG_JUST:      just_reg      <= cfg_data[0];
                    default:       ;
                endcase
            end
            case (op)
                OP_LOAD: begin
                    cmd_reg     <= in_cmd;
                    note_reg    <= in_data[6:0];
                    vel_reg     <= in_data[13:7];
                    gain_reg[0] <= in_data[29:14];
                    gain_reg[1] <= in_data[45:30];
                end
                OP_NOTE: begin
                    wrap_reg <= 1'b0;
                    case (cmd_t'(cmd_reg))
                        CMD_NOTE_ON: begin
                            if (vel_reg != 7'd0) begin
                                active_reg <= 1'b1;
                                held_reg   <= note_reg;
                                seed_reg   <= 32'(note_reg) * 32'd12345 + 32'd99999;
                                phase_reg  <= '0;
                            end else if (held_reg == note_reg) begin
                                active_reg <= 1'b0;
                            end
                        end
                        CMD_NOTE_OFF: begin
                            if (active_reg && held_reg == note_reg) active_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_PHASE: begin
                    phase_reg <= phase_sum[31:0];
                    wrap_reg  <= phase_sum[32];
                end
                OP_LCG:     seed_reg <= seed_reg * 32'd1664525 + 32'd1013904223;
                OP_UNQ: begin
                    tgt_reg[0] <= 24'd12800
                        + 24'((43'(rnd) * 43'd499200) >> RFB);
                end
                OP_ET_PICK: begin
                    pick_reg <= 7'((31'(rnd) * 31'(7'(range_reg) * 7'd6)) >> RFB);
                end
                OP_ET_NOTE: et_note_reg <= (et_sum > 8'd127) ? 7'd127 : et_sum[6:0];
                OP_FREQ:    tgt_reg[0]  <= 24'(note_freq(et_note_reg));
                OP_J_BASE: begin
                    jidx_reg <= rnd[RFB-1 -: 3];
                    base_reg <= 17'(note_freq(7'd48 + 7'(semi)));
                end
                OP_J_OCT: begin
                    oct_reg <= 3'((28'(rnd) * 28'(4'(maxo) + 4'd1)) >> RFB);
                end
                OP_J_MUL:   jprod_reg <= 21'(base_reg) * 21'(just_num(jidx_reg));
                OP_J_DIV: begin
                    if (just_den3(jidx_reg))
                        jquo_reg <= 20'((41'(jprod_reg) * 41'd699051) >> 21);
                    else
                        jquo_reg <= 20'(jprod_reg >> just_den_shift(jidx_reg));
                end
                OP_J_SHIFT: begin
                    tgt_reg[0] <= (jshift > 27'(PITCH_MAX)) ? 24'(PITCH_MAX) : jshift[23:0];
                end
                OP_CV2:     tgt_reg[2] <= 24'(rnd) << (24 - RFB);
                OP_CV1:     tgt_reg[1] <= 24'(rnd) << (24 - RFB);
                OP_SLEW_DIFF: begin
                    for (int i = 0; i < 3; i++)
                        diff_reg[i] <= (now_reg[i] < tgt_reg[i]) ? tgt_reg[i] - now_reg[i]
                                                                 : now_reg[i] - tgt_reg[i];
                end
                OP_SLEW_MUL: begin
                    for (int i = 0; i < 3; i++)
                        step_reg[i] <= 24'((40'(diff_reg[i]) * 40'(slew_coef_reg[15:0])) >> 16);
                end
                OP_SLEW_APPLY: begin
                    for (int i = 0; i < 3; i++) begin
                        if (now_reg[i] == tgt_reg[i] || slew_coef_reg == 17'd0) begin
                            now_reg[i] <= now_reg[i];
                        end else if (slew_coef_reg[16]) begin
                            now_reg[i] <= tgt_reg[i];
                        end else if (now_reg[i] < tgt_reg[i]) begin
                            now_reg[i] <= now_reg[i]
                                + ((step_reg[i] == 24'd0) ? 24'd1 : step_reg[i]);
                        end else begin
                            now_reg[i] <= now_reg[i]
                                - ((step_reg[i] == 24'd0) ? 24'd1 : step_reg[i]);
                        end
                    end
                end
                OP_DAC_MUL: begin
                    for (int i = 0; i < 2; i++)
                        dprod_reg[i] <= 40'(now_reg[i+1]) * 40'(gain_reg[i]);
                end
                OP_DAC_SCALE: begin
                    for (int i = 0; i < 2; i++)
                        code_reg[i] <= 12'((56'(dprod_reg[i]) * 56'(DAC_FULL)) >> 40);
                end
                OP_OUT: begin
                    out_data_reg <= {active_reg ? code_reg[1] : 12'd0,
                                     active_reg ? code_reg[0] : 12'd0,
                                     now_reg[0][22:0], active_reg};
                    out_new_reg  <= wrap_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/random_stepped_pitch_cv_generator_top.sv]
// Top level of the random stepped pitch CV generator.
// Joins the controller (rspcv_ctrl) and the datapath (rspcv_dp); types from rspcv_pkg.
//
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tuser command, s_tdata note/velocity/gains
// m_        out  m_tvalid/m_tready   m_tuser new_step, m_tdata gate/pitch/codes
// cfg_      in   cfg_we              cfg_index register, cfg_data value
//
// One transaction at a time. A note or idle-tick transaction loads, decodes, then runs the DAC
// multiply, DAC scale and output steps; an active tick runs phase, wrap check and slew steps first;
// a draw adds LCG, pitch and CV steps (unquantized, equal tempered or just) through the shared LCG.
// Reset is synchronous on aresetn low and restores configuration, note state, controller state and m_tvalid.
// A stalled result holds in the output register; the next transaction is accepted
// meanwhile and waits at its final step until the output register frees up.
module random_stepped_pitch_cv_generator_top import rspcv_pkg::*; #(
    parameter int RANDOM_FRACTION_BITS = 24,
    parameter int DAC_BITS             = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command
    input  logic [47:0] s_tdata,   // note[6:0], velocity[13:7], cv1_gain[29:14], cv2_gain[45:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // new_step
    output logic [47:0] m_tdata    // gate[0], pitch_freq[23:1], cv1_code[35:24], cv2_code[47:36]
);

    op_t        op;
    dp_status_t status;

    // sequence micro-ops and own both handshakes
    rspcv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    // hold configuration and state, execute one micro-op per cycle
    rspcv_dp #(
        .RANDOM_FRACTION_BITS (RANDOM_FRACTION_BITS),
        .DAC_BITS             (DAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (s_tuser),
        .in_data      (s_tdata),
        .op           (op),
        .status       (status),
        .out_data     (m_tdata),
        .out_new_step (m_tuser)
    );

endmodule
